/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/lsws_pkg.sv */
package lsws_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int VW          = 32;
  localparam int PW          = 7;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RS_FULL,
    RS_PUSH,
    RS_EMPTY_POP,
    RS_EMPTY,
    RS_POP,
    RS_FOUND,
    RS_MISSING,
    RS_DUMP
  } res_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CHECK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic     ld_item;
    logic     push;
    logic     pop;
    logic     rd_en;
    logic     inc_idx;
    logic     load;
    res_sel_e res_sel;
  } lsws_cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic match;
    logic search_last;
    logic dump_last;
  } lsws_sts_t;

endpackage

/* sv/lsws_ctrl.sv */
module lsws_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lsws_pkg::lsws_sts_t  sts_i,
  output lsws_pkg::lsws_cmd_t  cmd_o
);
  import lsws_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.res_sel = RS_FULL;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_PUSH: begin
            cmd_o.load = 1'b1;
            state_d    = S_OUT;
            if (sts_i.full) begin
              cmd_o.res_sel = RS_FULL;
            end else begin
              cmd_o.push    = 1'b1;
              cmd_o.res_sel = RS_PUSH;
            end
          end
          OP_POP: begin
            if (sts_i.empty) begin
              cmd_o.load    = 1'b1;
              cmd_o.res_sel = RS_EMPTY_POP;
              state_d       = S_OUT;
            end else begin
              cmd_o.pop   = 1'b1;
              cmd_o.rd_en = 1'b1;
              state_d     = S_CHECK;
            end
          end
          default: begin
            if (sts_i.empty) begin
              cmd_o.load    = 1'b1;
              cmd_o.res_sel = RS_EMPTY;
              state_d       = S_OUT;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_CHECK;
            end
          end
        endcase
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        case (sts_i.op)
          OP_SEARCH: begin
            if (sts_i.match) begin
              cmd_o.load    = 1'b1;
              cmd_o.res_sel = RS_FOUND;
              state_d       = S_OUT;
            end else if (sts_i.search_last) begin
              cmd_o.load    = 1'b1;
              cmd_o.res_sel = RS_MISSING;
              state_d       = S_OUT;
            end else begin
              cmd_o.inc_idx = 1'b1;
              state_d       = S_READ;
            end
          end
          OP_DUMP: begin
            cmd_o.load    = 1'b1;
            cmd_o.res_sel = RS_DUMP;
            state_d       = S_OUT;
          end
          default: begin
            cmd_o.load    = 1'b1;
            cmd_o.res_sel = RS_POP;
            state_d       = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.op == OP_DUMP && !sts_i.dump_last && !sts_i.empty) begin
            cmd_o.inc_idx = 1'b1;
            state_d       = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/lsws_dp.sv */
module lsws_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           opcode_i,
  input  logic signed [31:0]   value_i,
  input  lsws_pkg::lsws_cmd_t  cmd_i,
  output lsws_pkg::lsws_sts_t  sts_o,
  output logic signed [31:0]   value_res_o,
  output logic [6:0]           position_o,
  output logic [1:0]           status_o,
  output logic                 last_o
);
  import lsws_pkg::*;

  logic [VW-1:0] mem_q [DEPTH];
  logic [VW-1:0] rdata_q;
  logic [VW-1:0] val_q;
  op_e           op_q;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q;
  logic [CW-1:0] addr_full;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] cnt_w, lim_w, pos_w;

  logic [VW-1:0] res_value_d, res_value_q;
  logic [PW-1:0] res_pos_d, res_pos_q;
  status_e       res_st_d, res_st_q;
  logic          res_last_d, res_last_q;

  assign addr_full = count_q - CW'(1) - CW'(idx_q);
  assign rd_addr   = addr_full[AW-1:0];
  assign cnt_w     = PW'(count_q);
  assign lim_w     = (cnt_w > PW'(MAX_RESULTS)) ? PW'(MAX_RESULTS) : cnt_w;
  assign pos_w     = PW'(idx_q) + PW'(1);

  always_comb begin
    sts_o.op          = op_q;
    sts_o.empty       = (count_q == '0);
    sts_o.full        = (count_q == CW'(DEPTH));
    sts_o.match       = (rdata_q == val_q);
    sts_o.search_last = (pos_w == cnt_w);
    sts_o.dump_last   = (pos_w == lim_w);
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      op_q  <= op_e'(opcode_i);
      val_q <= value_i;
      idx_q <= '0;
    end else if (cmd_i.inc_idx) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[count_q[AW-1:0]] <= val_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    res_value_d = '0;
    res_pos_d   = '0;
    res_st_d    = ST_OK;
    res_last_d  = 1'b1;
    case (cmd_i.res_sel)
      RS_FULL:      res_st_d = ST_FULL;
      RS_PUSH:      res_value_d = val_q;
      RS_EMPTY_POP: begin
        res_value_d = '1;
        res_st_d    = ST_EMPTY;
      end
      RS_EMPTY:     res_st_d = ST_EMPTY;
      RS_POP:       res_value_d = rdata_q;
      RS_FOUND: begin
        res_value_d = val_q;
        res_pos_d   = pos_w;
      end
      RS_MISSING: begin
        res_value_d = val_q;
        res_st_d    = ST_MISSING;
      end
      RS_DUMP: begin
        res_value_d = rdata_q;
        res_last_d  = sts_o.dump_last;
      end
      default: res_st_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_value_q <= res_value_d;
      res_pos_q   <= res_pos_d;
      res_st_q    <= res_st_d;
      res_last_q  <= res_last_d;
    end
  end

  assign value_res_o = res_value_q;
  assign position_o  = res_pos_q;
  assign status_o    = res_st_q;
  assign last_o      = res_last_q;

endmodule

/* sv/lifo_stack_with_search.sv */
// Bounded LIFO stack of signed 32-bit words with search and dump.
// Input channel (in_valid_i/in_ready_o): opcode_i (push, pop, search, dump)
// and value_i. Output channel (out_valid_o/out_ready_i): value_res_o,
// position_o, status_o and last_o; last_o marks the final result of an item.
// One item is worked on at a time; in_ready_o is high only between items.
// From input transfer to result valid: push decodes in S_EXEC and registers
// its result into S_OUT; pop registers the memory read in S_EXEC and the
// result in S_CHECK; search does one registered memory read and one compare
// per entry (S_EXEC or S_READ, then S_CHECK); dump reads its first entry as
// pop does, and after each output transfer reads the next one via S_READ.
// An empty stack answers every non-push op straight from S_EXEC. A new item
// waits for the decode, read and output-hold states around the entry memory.
// A stalled receiver holds the result register; nothing advances until the
// output transfer. Reset empties the stack at once (count cleared); the
// entry memory is not cleared and needs no clearing pass.
module lifo_stack_with_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_res_o,
  output logic [6:0]         position_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import lsws_pkg::*;

  lsws_cmd_t cmd;
  lsws_sts_t sts;

  lsws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_res_o (value_res_o),
    .position_o  (position_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

/* sv/lsws_checker.sv */
`include "assert_macros.svh"

module lsws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         opcode_i,
  input logic signed [31:0] value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] value_res_o,
  input logic [6:0]         position_o,
  input logic [1:0]         status_o,
  input logic               last_o
);
  import lsws_pkg::*;

  logic [1:0] unused_op;
  logic signed [31:0] unused_val;
  assign unused_op  = opcode_i;
  assign unused_val = value_i;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_IMPLIES(a_one_side, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_IMPLIES(a_pos_ok, clk_i, rst_ni, out_valid_o && position_o != 7'd0, status_o == ST_OK)
  `ASSERT_IMPLIES(a_err_last, clk_i, rst_ni, out_valid_o && status_o != ST_OK, last_o && position_o == 7'd0)

endmodule

bind lifo_stack_with_search lsws_checker u_lsws_checker (.*);
